// File: rtl/wip_pkg.sv
// Package for the weighted pool-adjacent-violators engine: widths, codes,
// the block record kept in the stack RAM and the comparator request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wip_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int VAL_W  = 24;
  localparam int WIN_W  = 16;
  localparam int IDX_W  = 10;
  localparam int END_W  = 10;
  localparam int MEAN_W = 24;
  localparam int STAT_W = 2;

  // Block store widths
  localparam int SUM_W = 51;
  localparam int WGT_W = 26;

  // Cross-multiply unit: sums split in a low unsigned limb and a high signed limb
  localparam int LIMB_W = 26;
  localparam int MUL_W  = LIMB_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = SUM_W + WGT_W + 1;

  // Stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USED_W = CNT_W + END_W + MEAN_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_ZERO_WGT  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_CHECK,
    S_FETCH,
    S_CMP,
    S_RD_WAIT,
    S_DIV_GO,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [END_W-1:0]        last;
    logic [WGT_W-1:0]        weight;
    logic signed [SUM_W-1:0] sum;
  } blk_t;

  // Request to the comparator: is sp*wt >= st*wp ?
  typedef struct packed {
    logic signed [SUM_W-1:0] sp;
    logic [WGT_W-1:0]        wt;
    logic signed [SUM_W-1:0] st;
    logic [WGT_W-1:0]        wp;
  } cmp_req_t;

endpackage

`default_nettype wire

// File: rtl/wip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/wip_mac.sv
// Shared cross-multiply comparator: one 27x27 signed multiplier and a
// 78-bit accumulator that combines four partial products.
// Depends on wip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wip_mac (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wip_pkg::cmp_req_t req,
  output logic              done,
  output logic              ge
);

  wip_pkg::cmp_req_t                   op;
  logic                                busy;
  logic [2:0]                          cnt;
  logic                                pv;
  logic [1:0]                          ptag;
  logic signed [wip_pkg::MUL_W-1:0]    a;
  logic signed [wip_pkg::MUL_W-1:0]    b;
  logic signed [wip_pkg::PROD_W-1:0]   prod;
  logic signed [wip_pkg::ACC_W-1:0]    acc;
  logic signed [wip_pkg::ACC_W-1:0]    term;
  logic signed [wip_pkg::SUM_W-1:0]    s_sel;
  logic [wip_pkg::WGT_W-1:0]           w_sel;

  // tag bit 1: subtract side (st*wp); tag bit 0: high limb
  always_comb begin
    s_sel = cnt[1] ? op.st : op.sp;
    w_sel = cnt[1] ? op.wp : op.wt;
    if (cnt[0]) begin
      a = {{(wip_pkg::MUL_W - (wip_pkg::SUM_W - wip_pkg::LIMB_W)){s_sel[wip_pkg::SUM_W-1]}},
           s_sel[wip_pkg::SUM_W-1:wip_pkg::LIMB_W]};
    end else begin
      a = {1'b0, s_sel[wip_pkg::LIMB_W-1:0]};
    end
    b = {1'b0, w_sel};
  end

  always_comb begin
    term = {{(wip_pkg::ACC_W - wip_pkg::PROD_W){prod[wip_pkg::PROD_W-1]}}, prod};
    if (ptag[0]) begin
      term = term <<< wip_pkg::LIMB_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pv   <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 3'd4);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        pv   <= 1'b0;
      end else if (busy) begin
        pv  <= (cnt < 3'd4);
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
        end
      end else begin
        pv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op  <= req;
      acc <= '0;
    end else begin
      if (busy) begin
        prod <= a * b;
        ptag <= cnt[1:0];
      end
      if (pv) begin
        acc <= ptag[1] ? (acc - term) : (acc + term);
      end
    end
  end

  assign ge = ~acc[wip_pkg::ACC_W-1];

endmodule

`default_nettype wire

// File: rtl/wip_div.sv
// Restoring divider for block means: signed 51-bit sum over unsigned 26-bit
// weight, one quotient bit per cycle, truncated toward zero.
// Depends on wip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wip_div (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire signed [wip_pkg::SUM_W-1:0]    dividend,
  input  wire [wip_pkg::WGT_W-1:0]           divisor,
  output logic                               done,
  output logic signed [wip_pkg::MEAN_W-1:0]  quotient
);

  localparam int DSH_W = wip_pkg::WGT_W + wip_pkg::MEAN_W - 1;
  localparam int STEP_W = $clog2(wip_pkg::MEAN_W);

  logic                        busy;
  logic [STEP_W-1:0]           cnt;
  logic                        neg;
  logic [wip_pkg::SUM_W-1:0]   rem;
  logic [DSH_W-1:0]            dsh;
  logic [wip_pkg::MEAN_W-1:0]  q;
  logic [wip_pkg::SUM_W-1:0]   dsh_ext;
  logic                        fit;

  // Quotient magnitude never exceeds 2^23, so the divisor starts shifted by 23.
  assign dsh_ext = wip_pkg::SUM_W'(dsh);
  assign fit     = (rem >= dsh_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(wip_pkg::MEAN_W - 1);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[wip_pkg::SUM_W-1];
      rem <= dividend[wip_pkg::SUM_W-1] ? (wip_pkg::SUM_W'(0) - dividend) : dividend;
      dsh <= {divisor, {(wip_pkg::MEAN_W - 1){1'b0}}};
      q   <= '0;
    end else if (busy) begin
      if (fit) begin
        rem <= rem - dsh_ext;
      end
      q   <= {q[wip_pkg::MEAN_W-2:0], fit};
      dsh <= dsh >> 1;
    end
  end

  assign quotient = neg ? (wip_pkg::MEAN_W'(0) - q) : q;

endmodule

`default_nettype wire

// File: rtl/weighted_isotonic_pava.sv
// Weighted pool-adjacent-violators engine, top level: sequencer, stack RAM,
// comparator and divider.
// Depends on wip_pkg, wip_ram, wip_mac, wip_div.
//
// Usage
//   Slave channel s_*: one command per transfer. s_tuser carries the operation
//   (clear, push, read); s_tdata carries the point value, weight and the block
//   index to read. Master channel m_*: exactly one result per command, giving
//   the held block count, the reported block's last point index, its mean
//   (Q12.12, truncated toward zero) and a status code in m_tuser.
//   A push writes a new block, then merges it with the block below while the
//   lower mean is >= the top mean; every merge check reads the lower block
//   from the stack RAM and runs the shared cross-multiplier.
// Sequence from accept to result loaded in the output register
//   clear, unused op, rejected push or read: straight to the output state.
//   read: stack RAM read, then the bit-serial mean divider.
//   push: block write, then the merge checks, then the divider on the top block.
//   s_tready is high only while the sequencer is idle.
// The output register holds a finished result while m_tready is low, and a
// new command is accepted meanwhile; the sequencer waits in its last state only
// if it finishes the next result before the old one is taken.
// Reset (rst, synchronous, active high) empties the stack and the point
// count and drops m_tvalid; the stack RAM itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module weighted_isotonic_pava (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // [23:0] point_value, [39:24] point_weight, [49:40] block_index, rest zero
  input  wire [wip_pkg::IN_DATA_W-1:0]         s_tdata,
  // [1:0] operation
  input  wire [wip_pkg::OP_W-1:0]              s_tuser,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // [10:0] block_count, [20:11] block_end, [44:21] block_mean, rest zero
  output logic [wip_pkg::OUT_DATA_W-1:0]       m_tdata,
  // [1:0] status
  output logic [wip_pkg::STAT_W-1:0]           m_tuser
);

  wip_pkg::state_t  state, state_next;
  wip_pkg::op_t     op;

  logic [wip_pkg::CNT_W-1:0] held;
  logic [wip_pkg::CNT_W-1:0] pushed;
  logic [wip_pkg::CNT_W-1:0] held_m2;

  wip_pkg::blk_t    top;
  wip_pkg::blk_t    prev;
  wip_pkg::blk_t    merged;
  wip_pkg::blk_t    ram_rdata;
  wip_pkg::blk_t    ram_wdata;
  wip_pkg::blk_t    new_blk;
  wip_pkg::cmp_req_t cmp_req;

  logic                          ram_we;
  logic [wip_pkg::ADDR_W-1:0]    ram_waddr;
  logic [wip_pkg::ADDR_W-1:0]    ram_raddr;

  logic mac_start, mac_done, mac_ge;
  logic div_start, div_done;
  logic signed [wip_pkg::MEAN_W-1:0] div_q;

  wip_pkg::status_t                 res_status;
  logic [wip_pkg::END_W-1:0]        res_end;
  logic signed [wip_pkg::MEAN_W-1:0] res_mean;

  // input fields
  logic signed [wip_pkg::VAL_W-1:0] in_value;
  logic [wip_pkg::WIN_W-1:0]        in_weight;
  logic [wip_pkg::IDX_W-1:0]        in_index;

  logic accept, out_free, stack_full, bad_index;
  logic signed [wip_pkg::VAL_W+wip_pkg::WIN_W:0] point_prod;

  assign op        = wip_pkg::op_t'(s_tuser);
  assign in_value  = s_tdata[wip_pkg::VAL_W-1:0];
  assign in_weight = s_tdata[wip_pkg::VAL_W +: wip_pkg::WIN_W];
  assign in_index  = s_tdata[wip_pkg::VAL_W + wip_pkg::WIN_W +: wip_pkg::IDX_W];

  assign s_tready   = (state == wip_pkg::S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign stack_full = (pushed >= wip_pkg::CNT_W'(wip_pkg::MAX_POINTS)) ||
                      (held >= wip_pkg::CNT_W'(wip_pkg::MAX_POINTS));
  assign bad_index  = (wip_pkg::CNT_W'(in_index) >= held);
  assign held_m2    = held - wip_pkg::CNT_W'(2);

  // value * weight of the pushed point, exact
  assign point_prod     = in_value * $signed({1'b0, in_weight});
  assign new_blk.sum    = wip_pkg::SUM_W'(point_prod);
  assign new_blk.weight = wip_pkg::WGT_W'(in_weight);
  assign new_blk.last   = wip_pkg::END_W'(pushed);

  assign merged.sum    = prev.sum + top.sum;
  assign merged.weight = prev.weight + top.weight;
  assign merged.last   = top.last;

  assign cmp_req.sp = ram_rdata.sum;
  assign cmp_req.wt = top.weight;
  assign cmp_req.st = top.sum;
  assign cmp_req.wp = ram_rdata.weight;

  wip_ram #(
    .WIDTH ($bits(wip_pkg::blk_t)),
    .DEPTH (wip_pkg::MAX_POINTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wip_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .req   (cmp_req),
    .done  (mac_done),
    .ge    (mac_ge)
  );

  wip_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (top.sum),
    .divisor  (top.weight),
    .done     (div_done),
    .quotient (div_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wip_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer strobes
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = held[wip_pkg::ADDR_W-1:0];
    ram_wdata  = top;
    ram_raddr  = held_m2[wip_pkg::ADDR_W-1:0];
    mac_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      wip_pkg::S_IDLE: begin
        ram_raddr = wip_pkg::ADDR_W'(in_index);
        if (accept) begin
          state_next = wip_pkg::S_OUT;
          if (op == wip_pkg::OP_PUSH && !stack_full && in_weight != '0) begin
            state_next = wip_pkg::S_PUSH;
          end else if (op == wip_pkg::OP_READ && !bad_index) begin
            state_next = wip_pkg::S_RD_WAIT;
          end
        end
      end
      wip_pkg::S_PUSH: begin
        ram_we     = 1'b1;
        state_next = wip_pkg::S_CHECK;
      end
      wip_pkg::S_CHECK: begin
        // bottom block never merges downward
        state_next = (held >= wip_pkg::CNT_W'(2)) ? wip_pkg::S_FETCH : wip_pkg::S_DIV_GO;
      end
      wip_pkg::S_FETCH: begin
        mac_start  = 1'b1;
        state_next = wip_pkg::S_CMP;
      end
      wip_pkg::S_CMP: begin
        if (mac_done) begin
          if (mac_ge) begin
            ram_we     = 1'b1;
            ram_waddr  = held_m2[wip_pkg::ADDR_W-1:0];
            ram_wdata  = merged;
            state_next = wip_pkg::S_CHECK;
          end else begin
            state_next = wip_pkg::S_DIV_GO;
          end
        end
      end
      wip_pkg::S_RD_WAIT: begin
        state_next = wip_pkg::S_DIV_GO;
      end
      wip_pkg::S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = wip_pkg::S_DIV;
      end
      wip_pkg::S_DIV: begin
        if (div_done) begin
          state_next = wip_pkg::S_OUT;
        end
      end
      wip_pkg::S_OUT: begin
        if (out_free) begin
          state_next = wip_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wip_pkg::S_IDLE;
      end
    endcase
  end

  // stack and point counters
  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      pushed <= '0;
    end else begin
      if (accept && op == wip_pkg::OP_CLEAR) begin
        held   <= '0;
        pushed <= '0;
      end else if (state == wip_pkg::S_PUSH) begin
        held   <= held + wip_pkg::CNT_W'(1);
        pushed <= pushed + wip_pkg::CNT_W'(1);
      end else if (state == wip_pkg::S_CMP && mac_done && mac_ge) begin
        held <= held - wip_pkg::CNT_W'(1);
      end
    end
  end

  // output transfer handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == wip_pkg::S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // working block and result fields
  always_ff @(posedge clk) begin
    case (state)
      wip_pkg::S_IDLE: begin
        if (accept) begin
          res_end  <= '0;
          res_mean <= '0;
          if (op == wip_pkg::OP_PUSH && stack_full) begin
            res_status <= wip_pkg::ST_FULL;
          end else if (op == wip_pkg::OP_PUSH && in_weight == '0) begin
            res_status <= wip_pkg::ST_ZERO_WGT;
          end else if (op == wip_pkg::OP_READ && bad_index) begin
            res_status <= wip_pkg::ST_BAD_INDEX;
          end else begin
            res_status <= wip_pkg::ST_OK;
          end
          if (op == wip_pkg::OP_PUSH && !stack_full && in_weight != '0) begin
            top <= new_blk;
          end
        end
      end
      wip_pkg::S_RD_WAIT: top <= ram_rdata;
      wip_pkg::S_FETCH:   prev <= ram_rdata;
      wip_pkg::S_CMP: begin
        if (mac_done && mac_ge) begin
          top <= merged;
        end
      end
      wip_pkg::S_DIV_GO:  res_end <= top.last;
      wip_pkg::S_DIV: begin
        if (div_done) begin
          res_mean <= div_q;
        end
      end
      wip_pkg::S_OUT: begin
        if (out_free) begin
          m_tdata <= {{(wip_pkg::OUT_DATA_W - wip_pkg::OUT_USED_W){1'b0}},
                      res_mean, res_end, held};
          m_tuser <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/wip_checker.sv
// Port-level checks for weighted_isotonic_pava, bound to the top level.
// Depends on wip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wip_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire [wip_pkg::IN_DATA_W-1:0]     s_tdata,
  input wire [wip_pkg::OP_W-1:0]          s_tuser,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [wip_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire [wip_pkg::STAT_W-1:0]        m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // every accepted command moves the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after an accepted transfer");

  // failed commands report no block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != wip_pkg::ST_OK) |->
      m_tdata[wip_pkg::OUT_USED_W-1:wip_pkg::CNT_W] == '0)
    else $error("failed command reported block data");

  // block count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[wip_pkg::CNT_W-1:0] <= wip_pkg::CNT_W'(wip_pkg::MAX_POINTS))
    else $error("block count out of range");

  // reset leaves an idle, empty output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind weighted_isotonic_pava wip_checker u_wip_checker (.*);

`default_nettype wire
